// ===== hw/rtl/hybrid_logical_clock_top_defines.svh =====
// Assertion macros for the hybrid logical clock top-level RTL.
// Each macro expects clk and arst_n in scope.
`ifndef HYBRID_LOGICAL_CLOCK_TOP_DEFINES_SVH
`define HYBRID_LOGICAL_CLOCK_TOP_DEFINES_SVH

// Same-cycle implication.
`define HLC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define HLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/hlc_pkg.sv =====
package hlc_pkg;

	localparam int TIME_W = 64;
	localparam int COUNTER_BITS_DEF = 16;

	typedef enum logic [1:0] {
		CMD_LOCAL   = 2'd0,
		CMD_OBSERVE = 2'd1,
		CMD_RECEIVE = 2'd2,
		CMD_RESTORE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TOO_OLD = 2'd1,
		ST_TOO_NEW = 2'd2,
		ST_SKEW    = 2'd3
	} status_t;

	localparam logic [1:0] CFG_MIN_VALID = 2'd0;
	localparam logic [1:0] CFG_MAX_VALID = 2'd1;
	localparam logic [1:0] CFG_MAX_SKEW  = 2'd2;

	localparam logic [TIME_W-1:0] MIN_VALID_RST = '0;
	localparam logic [TIME_W-1:0] MAX_VALID_RST = '1;
	localparam logic [TIME_W-1:0] MAX_SKEW_RST  = 64'd3600000000000;

	typedef struct packed {
		logic [TIME_W-1:0] min_valid_time;
		logic [TIME_W-1:0] max_valid_time;
		logic [TIME_W-1:0] max_skew;
	} cfg_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [TIME_W-1:0] wall_clock;
		logic [TIME_W-1:0] remote_time;
	} item_t;

	typedef struct packed {
		logic [TIME_W-1:0] time_out;
		logic              accepted;
		status_t           status;
	} result_t;

	typedef struct packed {
		logic              write;
		logic [TIME_W-1:0] next_time;
	} upd_t;

endpackage

// ===== hw/rtl/hlc_in_if.sv =====
interface hlc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [63:0] wall_clock;
	logic [63:0] remote_time;

	modport source (output valid, output cmd, output wall_clock, output remote_time,
		input ready);
	modport sink (input valid, input cmd, input wall_clock, input remote_time,
		output ready);
endinterface

// ===== hw/rtl/hlc_out_if.sv =====
interface hlc_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] time_out;
	logic        accepted;
	logic [1:0]  status;

	modport source (output valid, output time_out, output accepted, output status,
		input ready);
	modport sink (input valid, input time_out, input accepted, input status,
		output ready);
endinterface

// ===== hw/rtl/hlc_cfg.sv =====
module hlc_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [63:0]       cfg_wdata,
	output hlc_pkg::cfg_t     cfg
);

	hlc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_valid_time <= hlc_pkg::MIN_VALID_RST;
			cfg_q.max_valid_time <= hlc_pkg::MAX_VALID_RST;
			cfg_q.max_skew       <= hlc_pkg::MAX_SKEW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				hlc_pkg::CFG_MIN_VALID: cfg_q.min_valid_time <= cfg_wdata;
				hlc_pkg::CFG_MAX_VALID: cfg_q.max_valid_time <= cfg_wdata;
				hlc_pkg::CFG_MAX_SKEW:  cfg_q.max_skew       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/hlc_merge.sv =====
module hlc_merge #(
	parameter int COUNTER_BITS = hlc_pkg::COUNTER_BITS_DEF
) (
	input  hlc_pkg::item_t   item,
	input  logic [63:0]      last_time,
	input  hlc_pkg::cfg_t    cfg,
	output hlc_pkg::result_t res,
	output hlc_pkg::upd_t    upd
);

	localparam logic [63:0] WALL_MASK = ~((64'd1 << COUNTER_BITS) - 64'd1);
	localparam logic [COUNTER_BITS-1:0] CNT_ONE = {{(COUNTER_BITS-1){1'b0}}, 1'b1};

	logic [64:0]             skew_sum;
	logic [63:0]             limit;
	logic [63:0]             sw, tw, lw, mx_st, nw;
	logic [COUNTER_BITS-1:0] sc, tc, cnt_max, bump, nc;
	logic                    skew_bad, is_rx;
	logic [63:0]             merged, local_time;
	hlc_pkg::status_t        chk_status;

	assign is_rx = (item.cmd == hlc_pkg::CMD_RECEIVE);
	assign bump  = is_rx ? CNT_ONE : '0;

	// Saturate wall + skew instead of wrapping.
	assign skew_sum = {1'b0, item.wall_clock} + {1'b0, cfg.max_skew};
	assign limit    = skew_sum[64] ? '1 : skew_sum[63:0];

	assign sw = item.remote_time & WALL_MASK;
	assign tw = last_time & WALL_MASK;
	assign lw = item.wall_clock & WALL_MASK;
	assign sc = item.remote_time[COUNTER_BITS-1:0];
	assign tc = last_time[COUNTER_BITS-1:0];

	assign skew_bad = (sw > limit);
	assign mx_st    = (sw > tw) ? sw : tw;
	assign nw       = (mx_st > lw) ? mx_st : lw;
	assign cnt_max  = (tc > sc) ? tc : sc;

	// Counter follows the sources whose wall part wins; local-only resets it.
	always_comb begin
		if (nw == tw) begin
			nc = ((nw == sw) ? cnt_max : tc) + bump;
		end else if (nw == sw) begin
			nc = sc + bump;
		end else begin
			nc = '0;
		end
	end

	assign merged     = {nw[63:COUNTER_BITS], nc};
	assign local_time = (lw > tw) ? lw : {tw[63:COUNTER_BITS], tc + CNT_ONE};

	always_comb begin
		if (item.remote_time < cfg.min_valid_time) begin
			chk_status = hlc_pkg::ST_TOO_OLD;
		end else if (item.remote_time > cfg.max_valid_time) begin
			chk_status = hlc_pkg::ST_TOO_NEW;
		end else begin
			chk_status = hlc_pkg::ST_OK;
		end
	end

	always_comb begin
		res.time_out  = '0;
		res.accepted  = 1'b0;
		res.status    = hlc_pkg::ST_OK;
		upd.write     = 1'b0;
		upd.next_time = '0;
		case (item.cmd)
			hlc_pkg::CMD_LOCAL: begin
				res.time_out  = local_time;
				res.accepted  = 1'b1;
				upd.write     = (local_time != '0);
				upd.next_time = local_time;
			end
			hlc_pkg::CMD_RESTORE: begin
				res.time_out  = item.remote_time;
				res.accepted  = 1'b1;
				upd.write     = 1'b1;
				upd.next_time = item.remote_time;
			end
			hlc_pkg::CMD_OBSERVE, hlc_pkg::CMD_RECEIVE: begin
				res.status = chk_status;
				if (chk_status == hlc_pkg::ST_OK) begin
					if (!is_rx && item.remote_time <= last_time) begin
						res.accepted = 1'b1;
					end else if (skew_bad) begin
						res.status = hlc_pkg::ST_SKEW;
					end else if (merged != '0) begin
						// zero means no time: drop it as a rejection
						res.accepted  = 1'b1;
						upd.write     = 1'b1;
						upd.next_time = merged;
						if (is_rx) begin
							res.time_out = merged;
						end
					end
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/hybrid_logical_clock_top.sv =====
// Channel   Dir  Payload                              Handshake
// in_ch     in   cmd, wall_clock, remote_time         valid/ready
// out_ch    out  time_out, accepted, status           valid/ready
// cfg       in   cfg_index, cfg_wdata                 cfg_we, no stall
//
// One transaction per cycle while the output is not stalled; an accepted
// transaction loads the input register and then the result register, which
// drives out_ch.valid. The loop through last_time is one pass of
// compare/max/add logic, which sets the clock period.
// Reset clears last_time to zero and loads the register defaults.
// A stalled output holds the result; the input register still takes one
// more transaction before in_ch.ready drops.
`include "hybrid_logical_clock_top_defines.svh"

module hybrid_logical_clock_top #(
	parameter int COUNTER_BITS = hlc_pkg::COUNTER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	hlc_in_if.sink      in_ch,
	hlc_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);

	hlc_pkg::cfg_t    cfg;
	hlc_pkg::item_t   item_s1;
	hlc_pkg::result_t res;
	hlc_pkg::result_t result_s2;
	hlc_pkg::upd_t    upd;
	logic             valid_s1, valid_s2;
	logic             in_fire, adv;
	logic [63:0]      last_time_q;

	hlc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	hlc_merge #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_merge (
		.item      (item_s1),
		.last_time (last_time_q),
		.cfg       (cfg),
		.res       (res),
		.upd       (upd)
	);

	assign adv         = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;
	assign in_fire     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			last_time_q <= '0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
			if (adv && upd.write) begin
				last_time_q <= upd.next_time;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.cmd         <= hlc_pkg::cmd_t'(in_ch.cmd);
			item_s1.wall_clock  <= in_ch.wall_clock;
			item_s1.remote_time <= in_ch.remote_time;
		end
		if (adv) begin
			result_s2 <= res;
		end
	end

	assign out_ch.valid    = valid_s2;
	assign out_ch.time_out = result_s2.time_out;
	assign out_ch.accepted = result_s2.accepted;
	assign out_ch.status   = result_s2.status;

	`HLC_ASSERT_NEXT(a_reject_keeps_state, adv && !res.accepted, last_time_q == $past(last_time_q), "rejected transaction changed last_time")
	`HLC_ASSERT_NOW(a_status_rejects, adv && res.status != hlc_pkg::ST_OK, !res.accepted, "non-ok status marked accepted")
	`HLC_ASSERT_NEXT(a_observe_zero, adv && item_s1.cmd == hlc_pkg::CMD_OBSERVE, out_ch.valid && out_ch.time_out == '0, "observe result time not zero")
	`HLC_ASSERT_NOW(a_rx_reject_zero, adv && item_s1.cmd == hlc_pkg::CMD_RECEIVE && !res.accepted, res.time_out == '0, "rejected receive returned a time")
	`HLC_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv, valid_s1 && $stable(item_s1), "input register lost a stalled transaction")

endmodule

// ===== sim/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CB          = hlc_pkg::COUNTER_BITS_DEF;
	localparam logic [63:0] CNT_M       = (64'd1 << CB) - 64'd1;
	localparam logic [63:0] WALL_M      = ~CNT_M;
	localparam int          STALL_LIMIT = 2000;
	localparam int          LONG_HOLD   = 250;

	typedef struct {
		bit               is_reg;
		logic [1:0]       reg_idx;
		logic [63:0]      reg_val;
		hlc_pkg::item_t   stim;
		bit               typed;
		hlc_pkg::result_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_wdata;

	hlc_in_if  in_ch();
	hlc_out_if out_ch();

	hybrid_logical_clock_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted clock state and register copies
	logic [63:0] hlc_time;
	logic [63:0] cfg_min;
	logic [63:0] cfg_max;
	logic [63:0] cfg_skew;
	logic [63:0] wall_ns;

	hlc_pkg::result_t hlc_results[$];
	dir_row_t         dir_rows[$];
	int               mismatches = 0;
	int               sent_count;
	bit               offering;
	bit               sink_holding = 1'b0;
	bit               hold_done = 1'b0;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// wall clock plus skew allowance, saturating at all ones
	function automatic logic [63:0] skew_limit(logic [63:0] wall);
		logic [64:0] sum;
		sum = {1'b0, wall} + {1'b0, cfg_skew};
		return sum[64] ? '1 : sum[63:0];
	endfunction

	function automatic hlc_pkg::result_t hlc_apply(hlc_pkg::item_t it);
		hlc_pkg::result_t r;
		logic [63:0]      lw, lc, rw, rc, nw, nc, nt;
		r  = '{64'd0, 1'b0, hlc_pkg::ST_OK};
		lw = hlc_time & WALL_M;
		lc = hlc_time & CNT_M;
		rw = it.remote_time & WALL_M;
		rc = it.remote_time & CNT_M;
		case (it.cmd)
			hlc_pkg::CMD_LOCAL: begin
				nt = it.wall_clock & WALL_M;
				if (nt <= lw)
					nt = lw | ((hlc_time + 64'd1) & CNT_M);
				if (nt != 0)
					hlc_time = nt;
				r.time_out = nt;
				r.accepted = 1'b1;
			end
			hlc_pkg::CMD_RESTORE: begin
				hlc_time   = it.remote_time;
				r.time_out = it.remote_time;
				r.accepted = 1'b1;
			end
			default: begin
				if (it.remote_time < cfg_min)
					r.status = hlc_pkg::ST_TOO_OLD;
				else if (it.remote_time > cfg_max)
					r.status = hlc_pkg::ST_TOO_NEW;
				else if (it.cmd == hlc_pkg::CMD_OBSERVE && it.remote_time <= hlc_time)
					r.accepted = 1'b1;
				else if (rw > skew_limit(it.wall_clock))
					r.status = hlc_pkg::ST_SKEW;
				else begin
					nw = rw;
					if (lw > nw) nw = lw;
					if (it.wall_clock > nw) nw = it.wall_clock;
					nw = nw & WALL_M;
					nc = 64'd0;
					// counter comes from the sources that own the winning wall part
					if (nw == lw) begin
						nc = (nw == rw && rc > lc) ? rc : lc;
						if (it.cmd == hlc_pkg::CMD_RECEIVE) nc = nc + 64'd1;
					end else if (nw == rw) begin
						nc = rc;
						if (it.cmd == hlc_pkg::CMD_RECEIVE) nc = nc + 64'd1;
					end
					nt = nw | (nc & CNT_M);
					if (nt != 0) begin
						hlc_time   = nt;
						r.accepted = 1'b1;
						if (it.cmd == hlc_pkg::CMD_RECEIVE) r.time_out = nt;
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic hlc_pkg::item_t next_item();
		hlc_pkg::item_t it;
		int             r;
		logic [63:0]    cnt;
		r = $urandom_range(0, 99);
		if (r < 5)
			wall_ns = rand64();
		else if (r < 12)
			wall_ns = wall_ns - (64'($urandom_range(0, 3)) << CB);
		else if (r < 70)
			wall_ns = wall_ns + (64'($urandom_range(0, 2)) << CB);
		else
			wall_ns = wall_ns + 64'($urandom_range(0, 40000));
		it.wall_clock = wall_ns;

		r = $urandom_range(0, 99);
		it.cmd = (r < 30) ? hlc_pkg::CMD_LOCAL : (r < 55) ? hlc_pkg::CMD_OBSERVE :
			(r < 90) ? hlc_pkg::CMD_RECEIVE : hlc_pkg::CMD_RESTORE;

		case ($urandom_range(0, 2))
			0:       cnt = 64'd0;
			1:       cnt = CNT_M;
			default: cnt = 64'($urandom) & CNT_M;
		endcase

		r = $urandom_range(0, 99);
		if (it.cmd == hlc_pkg::CMD_RESTORE) begin
			if (r < 40)
				it.remote_time = rand64();
			else if (r < 70)
				it.remote_time = (hlc_time & WALL_M) | cnt;
			else if (r < 85)
				it.remote_time = 64'($urandom_range(0, 'h1FFFF));
			else
				it.remote_time = ~64'($urandom_range(0, 'h1FFFF));
		end else if (r < 35)
			it.remote_time = hlc_time + 64'($urandom_range(0, 6)) - 64'd3;
		else if (r < 60)
			it.remote_time = ((hlc_time & WALL_M) + (64'($urandom_range(0, 6)) << CB)
				- (64'd3 << CB)) | cnt;
		else if (r < 70) begin
			case ($urandom_range(0, 3))
				0:       it.remote_time = cfg_min - 64'd1;
				1:       it.remote_time = cfg_min;
				2:       it.remote_time = cfg_max;
				default: it.remote_time = cfg_max + 64'd1;
			endcase
		end else if (r < 80)
			it.remote_time = ((skew_limit(wall_ns) & WALL_M)
				+ (64'($urandom_range(0, 2)) << CB) - (64'd1 << CB)) | cnt;
		else if (r < 88)
			it.remote_time = (wall_ns & WALL_M) | cnt;
		else
			it.remote_time = rand64();
		return it;
	endfunction

	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic dir_row_t row(hlc_pkg::cmd_t c, logic [63:0] w, logic [63:0] rt);
		dir_row_t d;
		d.is_reg  = 1'b0;
		d.reg_idx = hlc_pkg::CFG_MIN_VALID;
		d.reg_val = '0;
		d.stim    = '{c, w, rt};
		d.typed   = 1'b0;
		d.want    = '{64'd0, 1'b0, hlc_pkg::ST_OK};
		return d;
	endfunction

	function automatic dir_row_t row_want(hlc_pkg::cmd_t c, logic [63:0] w,
		logic [63:0] rt, logic [63:0] t, logic a, hlc_pkg::status_t s);
		dir_row_t d;
		d       = row(c, w, rt);
		d.typed = 1'b1;
		d.want  = '{t, a, s};
		return d;
	endfunction

	function automatic dir_row_t row_reg(logic [1:0] idx, logic [63:0] v);
		dir_row_t d;
		d         = row(hlc_pkg::CMD_LOCAL, '0, '0);
		d.is_reg  = 1'b1;
		d.reg_idx = idx;
		d.reg_val = v;
		return d;
	endfunction

	task automatic offer(hlc_pkg::item_t it, bit typed, hlc_pkg::result_t want);
		hlc_pkg::result_t r;
		in_ch.valid       <= 1'b1;
		in_ch.cmd         <= it.cmd;
		in_ch.wall_clock  <= it.wall_clock;
		in_ch.remote_time <= it.remote_time;
		offering = 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		r = hlc_apply(it);
		hlc_results.push_back(typed ? want : r);
		sent_count++;
	endtask

	task automatic pause_input(int n);
		if (offering) begin
			in_ch.valid <= 1'b0;
			offering = 1'b0;
		end
		repeat (n) @(posedge clk);
	endtask

	// drop valid and wait out every outstanding result plus pipeline depth
	task automatic settle_block();
		pause_input(0);
		while (hlc_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [63:0] val);
		settle_block();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			hlc_pkg::CFG_MIN_VALID: cfg_min  = val;
			hlc_pkg::CFG_MAX_VALID: cfg_max  = val;
			hlc_pkg::CFG_MAX_SKEW:  cfg_skew = val;
			default: ;
		endcase
	endtask

	task automatic flag_mismatch(string field, logic [63:0] want, logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s mismatch: expected %h, got %h", $realtime, field, want, got);
	endtask

	always @(posedge clk) begin : result_check
		hlc_pkg::result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (hlc_results.size() == 0)
				flag_mismatch("unexpected transaction", '0, out_ch.time_out);
			else begin
				want = hlc_results.pop_front();
				if (out_ch.time_out !== want.time_out)
					flag_mismatch("time_out", want.time_out, out_ch.time_out);
				if (out_ch.accepted !== want.accepted)
					flag_mismatch("accepted", 64'(want.accepted), 64'(out_ch.accepted));
				if (out_ch.status !== want.status)
					flag_mismatch("status", 64'(want.status), 64'(out_ch.status));
			end
		end
	end

	initial begin : result_sink
		int calm, n;
		calm         = 0;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// hold off long enough for the input side to back up
			if (!hold_done && sent_count >= 400) begin
				sink_holding = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				sink_holding = 1'b0;
				hold_done    = 1'b1;
			end
			n = idle_len(calm);
			if (n > 0) begin
				out_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		int calm, gap, n_items;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = hlc_pkg::CFG_MIN_VALID;
		cfg_wdata         = '0;
		in_ch.valid       = 1'b0;
		in_ch.cmd         = hlc_pkg::CMD_LOCAL;
		in_ch.wall_clock  = '0;
		in_ch.remote_time = '0;
		hlc_time          = '0;
		cfg_min           = hlc_pkg::MIN_VALID_RST;
		cfg_max           = hlc_pkg::MAX_VALID_RST;
		cfg_skew          = hlc_pkg::MAX_SKEW_RST;
		wall_ns           = 64'h0000_1000_0000_0000;
		sent_count        = 0;
		offering          = 1'b0;
		calm              = 0;

		// register defaults, wall part and counter edges
		dir_rows.push_back(row_want(hlc_pkg::CMD_LOCAL, '0, '0, 64'd1, 1'b1,
			hlc_pkg::ST_OK));
		dir_rows.push_back(row(hlc_pkg::CMD_LOCAL, 64'hFFFF, '0));
		dir_rows.push_back(row_want(hlc_pkg::CMD_LOCAL, '1, '0, 64'hFFFF_FFFF_FFFF_0000,
			1'b1, hlc_pkg::ST_OK));
		dir_rows.push_back(row(hlc_pkg::CMD_LOCAL, '0, '0));
		dir_rows.push_back(row_want(hlc_pkg::CMD_RESTORE, '0, '1, '1, 1'b1,
			hlc_pkg::ST_OK));
		dir_rows.push_back(row(hlc_pkg::CMD_LOCAL, '0, '0));
		dir_rows.push_back(row_want(hlc_pkg::CMD_RESTORE, '1, '0, '0, 1'b1,
			hlc_pkg::ST_OK));
		dir_rows.push_back(row_want(hlc_pkg::CMD_OBSERVE, '0, '0, '0, 1'b1,
			hlc_pkg::ST_OK));
		dir_rows.push_back(row_want(hlc_pkg::CMD_RECEIVE, '0, '0, 64'd1, 1'b1,
			hlc_pkg::ST_OK));
		dir_rows.push_back(row_want(hlc_pkg::CMD_RESTORE, '0, 64'hFFFF, 64'hFFFF, 1'b1,
			hlc_pkg::ST_OK));
		// counter wraps to a zero time: state holds, receive reads as rejected
		dir_rows.push_back(row_want(hlc_pkg::CMD_LOCAL, '0, '0, '0, 1'b1,
			hlc_pkg::ST_OK));
		dir_rows.push_back(row_want(hlc_pkg::CMD_RECEIVE, '0, 64'hFFFF, '0, 1'b0,
			hlc_pkg::ST_OK));
		dir_rows.push_back(row(hlc_pkg::CMD_OBSERVE, '0, 64'h1_0000));
		dir_rows.push_back(row_want(hlc_pkg::CMD_RECEIVE, '0, 64'h0000_0400_0000_0000,
			'0, 1'b0, hlc_pkg::ST_SKEW));
		// skew sum saturates instead of wrapping
		dir_rows.push_back(row(hlc_pkg::CMD_RECEIVE, '1, '1));
		dir_rows.push_back(row(hlc_pkg::CMD_OBSERVE, 64'h1234_5678_9ABC_DEF0,
			64'hAAAA_5555_AAAA_5555));
		dir_rows.push_back(row_reg(hlc_pkg::CFG_MIN_VALID, 64'h1000));
		dir_rows.push_back(row_reg(hlc_pkg::CFG_MAX_VALID, 64'h8000_0000_0000_0000));
		dir_rows.push_back(row_reg(hlc_pkg::CFG_MAX_SKEW, '0));
		dir_rows.push_back(row_want(hlc_pkg::CMD_RESTORE, '0, 64'h2000, 64'h2000, 1'b1,
			hlc_pkg::ST_OK));
		dir_rows.push_back(row_want(hlc_pkg::CMD_OBSERVE, '0, 64'hFFF, '0, 1'b0,
			hlc_pkg::ST_TOO_OLD));
		dir_rows.push_back(row_want(hlc_pkg::CMD_RECEIVE, '0, 64'h8000_0000_0000_0001,
			'0, 1'b0, hlc_pkg::ST_TOO_NEW));
		dir_rows.push_back(row_want(hlc_pkg::CMD_RECEIVE, '0, 64'h8000_0000_0000_0000,
			'0, 1'b0, hlc_pkg::ST_SKEW));
		dir_rows.push_back(row_want(hlc_pkg::CMD_OBSERVE, '0, 64'h1000, '0, 1'b1,
			hlc_pkg::ST_OK));
		// only the local wall part wins: counter restarts without a bump
		dir_rows.push_back(row(hlc_pkg::CMD_RECEIVE, 64'h3_0000, 64'h2_0005));
		dir_rows.push_back(row(hlc_pkg::CMD_LOCAL, '0, '0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_reg)
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			else begin
				offer(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
				gap = idle_len(calm);
				if (gap > 0) pause_input(gap);
			end
		end

		for (int p = 0; p < 7; p++) begin
			n_items = (p >= 5) ? 60 : 200;
			case (p)
				0: begin
					write_reg(hlc_pkg::CFG_MIN_VALID, hlc_pkg::MIN_VALID_RST);
					write_reg(hlc_pkg::CFG_MAX_VALID, hlc_pkg::MAX_VALID_RST);
					write_reg(hlc_pkg::CFG_MAX_SKEW, hlc_pkg::MAX_SKEW_RST);
				end
				1: write_reg(hlc_pkg::CFG_MAX_SKEW, '0);
				2: write_reg(hlc_pkg::CFG_MAX_SKEW, '1);
				3: begin
					write_reg(hlc_pkg::CFG_MIN_VALID,
						hlc_time - 64'($urandom_range(0, 'h4_0000)));
					write_reg(hlc_pkg::CFG_MAX_VALID,
						hlc_time + 64'($urandom_range(0, 'hFF_FFFF)));
					write_reg(hlc_pkg::CFG_MAX_SKEW, 64'($urandom_range(0, 'h10_0000)));
				end
				4: begin
					write_reg(hlc_pkg::CFG_MIN_VALID, rand64());
					write_reg(hlc_pkg::CFG_MAX_VALID, rand64());
					write_reg(hlc_pkg::CFG_MAX_SKEW, rand64());
				end
				5: begin
					write_reg(hlc_pkg::CFG_MIN_VALID, '1);
					write_reg(hlc_pkg::CFG_MAX_VALID, '1);
					write_reg(hlc_pkg::CFG_MAX_SKEW, 64'h0000_0001_0000_0000);
				end
				default: begin
					write_reg(hlc_pkg::CFG_MIN_VALID, '0);
					write_reg(hlc_pkg::CFG_MAX_VALID, '0);
					write_reg(hlc_pkg::CFG_MAX_SKEW, hlc_pkg::MAX_SKEW_RST);
				end
			endcase
			for (int k = 0; k < n_items; k++) begin
				offer(next_item(), 1'b0, '0);
				if (p == 2 && k == 100)
					settle_block();
				else if (!sink_holding) begin
					gap = idle_len(calm);
					if (gap > 0) pause_input(gap);
				end
			end
		end

		settle_block();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && hlc_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/hlc_pkg.sv
hw/rtl/hlc_in_if.sv
hw/rtl/hlc_out_if.sv
hw/rtl/hlc_cfg.sv
hw/rtl/hlc_merge.sv
hw/rtl/hybrid_logical_clock_top.sv
sim/tb.sv
